// ----- sv/bopa_pkg.sv -----
// Shared types and constants for the bitmap object pool allocator.
// Used by the divider, the top level and the testbench; depends on nothing else.
`timescale 1ns / 1ps

package bopa_pkg;

   localparam int ADDR_W    = 48;  // object addresses and pool base
   localparam int SIZE_W    = 16;  // object size in bytes
   localparam int CNT_W     = 7;   // slot count register
   localparam int SLOT_ID_W = 7;   // signed slot index on the result side
   localparam int STATUS_W  = 2;
   localparam int CSR_AW    = 2;

   // The bitmap is kept as rows of this many slots.
   localparam int ROW_BITS  = 8;
   localparam int BIT_AW    = $clog2(ROW_BITS);

   // A free's offset is below object_size * 64, so the quotient fits here.
   localparam int QUO_W     = 7;
   localparam int DVD_W     = SIZE_W + QUO_W;

   localparam logic [SLOT_ID_W-1:0] SLOT_NONE = '1;  // -1

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [CSR_AW-1:0] CSR_POOL_BASE    = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_OBJECT_SIZE  = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_SLOTS_IN_USE = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_STRAY = 2'd2
   } status_type;

   // Result of the serial divider, valid for one cycle when done is high.
   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
      logic             rem_zero;
   } div_rsp_type;

endpackage

// ----- sv/bitmap_object_pool_allocator.sv -----
// Top level of the bitmap object pool allocator: control sequencer, shared
// multiplier and result register. Depends on bopa_pkg, bopa_ram and bopa_div.
`timescale 1ns / 1ps

// The block hands out equal-size object slots from a pool at pool_base and
// takes them back. Each request word carries the kind in req_tuser (0 to
// allocate, 1 to free) and, for a free, the object address in req_tdata.
// Each request produces exactly one response word: a status in rsp_tuser
// (0 success, 1 pool full, 2 stray free), the slot index (-1 when none) and,
// for an allocation, the object address pool_base + object_size * index.
// The use bitmap lives in a small RAM of 8-slot rows with a registered read;
// every row reads as all free after reset, so no clearing pass is needed.
// Requests are handled one at a time. An allocation scans the rows in order,
// each in a read and a check state, then forms the address in a multiply
// and an add state; its time is set by the row scan through the RAM read
// port. A free spends most of its time in the bit-serial divider that turns
// the address offset into a slot index. A finished response waits in its
// own register, so the next request is taken while the previous response
// is still unclaimed. The user writes configuration (csr_we/csr_addr/
// csr_wdata) only while no request is in flight; the block does not enforce it.

module bitmap_object_pool_allocator
   import bopa_pkg::*;
#(
   parameter int MAX_SLOTS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [ADDR_W-1:0]     req_tdata,   // [47:0] free_addr
   input  logic                  req_tuser,   // [0] op
   // Response channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [55:0]           rsp_tdata,   // [6:0] slot_id, [54:7] object_addr, [55] zero
   output logic [STATUS_W-1:0]   rsp_tuser,   // [1:0] status
   // Configuration write port.
   input  logic                  csr_we,
   input  logic [CSR_AW-1:0]     csr_addr,
   input  logic [ADDR_W-1:0]     csr_wdata
);

   localparam int ROWS   = (MAX_SLOTS + ROW_BITS - 1) / ROW_BITS;
   localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int PROD_W = SIZE_W + CNT_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_A_READ,
      ST_A_CHECK,
      ST_A_MUL,
      ST_A_ADD,
      ST_F_OFF,
      ST_F_RANGE,
      ST_F_DIV,
      ST_F_READ,
      ST_F_CLEAR,
      ST_OUT
   } state_type;

   state_type state_ff;

   // Configuration registers.
   logic [ADDR_W-1:0]    base_ff;
   logic [SIZE_W-1:0]    size_ff;
   logic [CNT_W-1:0]     slots_ff;

   // Request in flight.
   logic [ADDR_W-1:0]    addr_ff;
   logic [ROW_AW-1:0]    row_ff;
   logic [SLOT_ID_W-1:0] idx_ff;
   logic [ADDR_W-1:0]    off_ff;
   logic                 ok_ff;
   logic [PROD_W-1:0]    prod_ff;

   // Result waiting to enter the response register.
   status_type           res_status_ff;
   logic [SLOT_ID_W-1:0] res_id_ff;
   logic [ADDR_W-1:0]    res_addr_ff;

   // Response register.
   logic                 rsp_valid_ff;
   status_type           rsp_status_ff;
   logic [SLOT_ID_W-1:0] rsp_id_ff;
   logic [ADDR_W-1:0]    rsp_addr_ff;

   // A row that has never been written reads as all free.
   logic [ROWS-1:0]      row_valid_ff;

   logic [CNT_W-1:0]     slot_count;
   logic [ROW_BITS-1:0]  rd_data;
   logic [ROW_BITS-1:0]  word;
   logic [CNT_W-1:0]     row_base;
   logic [CNT_W-1:0]     next_base;
   logic                 found;
   logic [BIT_AW-1:0]    hit;
   logic                 scan_end;
   logic [CNT_W-1:0]     mul_b;
   logic [PROD_W-1:0]    prod_in;
   logic [ADDR_W:0]      diff;
   logic                 range_ok;
   logic                 div_start;
   div_rsp_type          div_rsp;
   logic                 ram_we;
   logic [ROW_BITS-1:0]  ram_wdata;

   // Slot counts above the built capacity count as the capacity.
   assign slot_count = (slots_ff > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : slots_ff;

   assign word      = row_valid_ff[row_ff] ? rd_data : '0;
   assign row_base  = CNT_W'({row_ff, BIT_AW'(0)});
   assign next_base = row_base + CNT_W'(ROW_BITS);
   assign scan_end  = (next_base >= slot_count) || (row_ff == ROW_AW'(ROWS - 1));

   // Lowest free slot of the current row that still lies inside the pool.
   always_comb begin
      found = 1'b0;
      hit   = '0;
      for (int b = ROW_BITS - 1; b >= 0; b--) begin
         if (!word[b] && ((row_base + CNT_W'(b)) < slot_count)) begin
            found = 1'b1;
            hit   = BIT_AW'(b);
         end
      end
   end

   // One multiplier serves both the object address and the pool span.
   assign mul_b   = (state_ff == ST_A_MUL) ? idx_ff : slot_count;
   assign prod_in = PROD_W'(size_ff) * PROD_W'(mul_b);

   assign diff     = {1'b0, addr_ff} - {1'b0, base_ff};
   assign range_ok = ok_ff && (off_ff < ADDR_W'(prod_ff));
   assign div_start = (state_ff == ST_F_RANGE) && range_ok;

   assign ram_we    = ((state_ff == ST_A_CHECK) && found) || (state_ff == ST_F_CLEAR);
   assign ram_wdata = (state_ff == ST_F_CLEAR)
                    ? (word & ~(ROW_BITS'(1) << idx_ff[BIT_AW-1:0]))
                    : (word | (ROW_BITS'(1) << hit));

   bopa_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (ROWS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (row_ff),
      .wr_data (ram_wdata),
      .rd_addr (row_ff),
      .rd_data (rd_data)
   );

   bopa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (off_ff[DVD_W-1:0]),
      .divisor  (size_ff),
      .rsp      (div_rsp)
   );

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         size_ff  <= SIZE_W'(64);
         slots_ff <= CNT_W'(64);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_POOL_BASE:    base_ff  <= csr_wdata;
            CSR_OBJECT_SIZE:  size_ff  <= csr_wdata[SIZE_W-1:0];
            CSR_SLOTS_IN_USE: slots_ff <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Request sequencer and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         row_valid_ff <= '0;
      end else begin
         // In ST_OUT the register is reloaded in the same cycle it drains.
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         if (ram_we) begin
            row_valid_ff[row_ff] <= 1'b1;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  addr_ff  <= req_tdata;
                  row_ff   <= '0;
                  state_ff <= (req_tuser == OP_FREE) ? ST_F_OFF : ST_A_READ;
               end
            end

            ST_A_READ: begin
               state_ff <= ST_A_CHECK;
            end

            ST_A_CHECK: begin
               if (found) begin
                  idx_ff   <= row_base + CNT_W'(hit);
                  state_ff <= ST_A_MUL;
               end else if (scan_end) begin
                  res_status_ff <= STATUS_FULL;
                  res_id_ff     <= SLOT_NONE;
                  res_addr_ff   <= '0;
                  state_ff      <= ST_OUT;
               end else begin
                  row_ff   <= row_ff + 1'b1;
                  state_ff <= ST_A_READ;
               end
            end

            ST_A_MUL: begin
               prod_ff  <= prod_in;
               state_ff <= ST_A_ADD;
            end

            ST_A_ADD: begin
               res_status_ff <= STATUS_OK;
               res_id_ff     <= idx_ff;
               res_addr_ff   <= base_ff + ADDR_W'(prod_ff);
               state_ff      <= ST_OUT;
            end

            ST_F_OFF: begin
               // The offset must not be negative and the pool must cover bytes.
               off_ff   <= diff[ADDR_W-1:0];
               ok_ff    <= !diff[ADDR_W] && (size_ff != '0);
               prod_ff  <= prod_in;
               state_ff <= ST_F_RANGE;
            end

            ST_F_RANGE: begin
               if (range_ok) begin
                  state_ff <= ST_F_DIV;
               end else begin
                  res_status_ff <= STATUS_STRAY;
                  res_id_ff     <= SLOT_NONE;
                  res_addr_ff   <= '0;
                  state_ff      <= ST_OUT;
               end
            end

            ST_F_DIV: begin
               if (div_rsp.done) begin
                  if (div_rsp.rem_zero) begin
                     idx_ff   <= SLOT_ID_W'(div_rsp.quotient);
                     row_ff   <= ROW_AW'(div_rsp.quotient >> BIT_AW);
                     state_ff <= ST_F_READ;
                  end else begin
                     res_status_ff <= STATUS_STRAY;
                     res_id_ff     <= SLOT_NONE;
                     res_addr_ff   <= '0;
                     state_ff      <= ST_OUT;
                  end
               end
            end

            ST_F_READ: begin
               state_ff <= ST_F_CLEAR;
            end

            ST_F_CLEAR: begin
               // Freeing a slot that is already free is not an error.
               res_status_ff <= STATUS_OK;
               res_id_ff     <= idx_ff;
               res_addr_ff   <= '0;
               state_ff      <= ST_OUT;
            end

            ST_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_id_ff     <= res_id_ff;
                  rsp_addr_ff   <= res_addr_ff;
                  state_ff      <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_addr_ff, rsp_id_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ----- sv/bopa_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read.
// Standalone; no package dependencies.
`timescale 1ns / 1ps

module bopa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ----- sv/bopa_div.sv -----
// Restoring serial divider that yields one quotient bit per cycle.
// Depends on bopa_pkg for widths and the result struct.
`timescale 1ns / 1ps

module bopa_div
   import bopa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DVD_W-1:0]  dividend,
   input  logic [SIZE_W-1:0] divisor,
   output div_rsp_type       rsp
);

   logic                     busy_ff;
   logic                     done_ff;
   logic [$clog2(QUO_W)-1:0] cnt_ff;
   logic [DVD_W-1:0]         rem_ff;
   logic [DVD_W-1:0]         dsr_ff;
   logic [QUO_W-1:0]         quo_ff;
   logic                     take_in;

   // The shifted divisor is compared against the partial remainder each step.
   assign take_in = (rem_ff >= dsr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= ($clog2(QUO_W))'(QUO_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend;
         dsr_ff <= DVD_W'(divisor) << (QUO_W - 1);
         quo_ff <= '0;
      end else if (busy_ff) begin
         if (take_in) begin
            rem_ff <= rem_ff - dsr_ff;
         end
         dsr_ff <= dsr_ff >> 1;
         quo_ff <= {quo_ff[QUO_W-2:0], take_in};
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;
   assign rsp.rem_zero = (rem_ff == '0);

endmodule

// ----- tb/tb_bitmap_object_pool_allocator.sv -----
// Self-checking testbench for bitmap_object_pool_allocator. It streams allocate
// and free words, predicts each response word from its own copy of the bitmap
// and configuration, and checks every field. Depends on bopa_pkg and the RTL.
`timescale 1ns / 1ps

module tb_bitmap_object_pool_allocator;
   import bopa_pkg::*;

   localparam int POOL_CAP    = 64;
   localparam int IDLE_PCT    = 19;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE      = 40;
   localparam logic [ADDR_W-1:0] ADDR_TOP = '1;

   typedef struct {
      logic              op;
      logic [ADDR_W-1:0] addr;
   } pool_req_type;

   typedef struct {
      status_type           status;
      logic [SLOT_ID_W-1:0] slot;
      logic [ADDR_W-1:0]    object_addr;
   } pool_reply_type;

   // Every input of the block starts at a known value.
   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ADDR_W-1:0]   req_tdata  = '0;
   logic                req_tuser  = OP_ALLOC;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [55:0]         rsp_tdata;
   logic [STATUS_W-1:0] rsp_tuser;
   logic                csr_we     = 1'b0;
   logic [CSR_AW-1:0]   csr_addr   = CSR_POOL_BASE;
   logic [ADDR_W-1:0]   csr_wdata  = '0;

   // The testbench's own copy of the configuration and of the use bitmap.
   // The configuration copy changes only while the block is idle, so the
   // prediction made at the moment a request word is accepted is exact.
   logic [ADDR_W-1:0]   cfg_base  = '0;
   logic [SIZE_W-1:0]   cfg_size  = 16'd64;
   logic [CNT_W-1:0]    cfg_slots = 7'd64;
   logic [POOL_CAP-1:0] used_map  = '0;

   pool_req_type   request_q[$];  // words waiting to be offered
   pool_reply_type reply_q[$];    // responses owed by the block, oldest first
   int             error_count = 0;

   // Idling control: no_gaps turns off random gaps on both sides, and each
   // increment of hold_asks makes the receiver start one long hold-off.
   bit          no_gaps   = 1'b0;
   int          hold_asks = 0;
   int          hold_seen = 0;
   int          hold_left = 0;

   bitmap_object_pool_allocator #(
      .MAX_SLOTS(POOL_CAP)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Number of slots the pool really has: the register saturates at capacity.
   function automatic int slot_limit();
      return (cfg_slots > POOL_CAP) ? POOL_CAP : int'(cfg_slots);
   endfunction

   // Works out the response to one request and updates the bitmap copy.
   function automatic pool_reply_type pool_outcome(logic op, logic [ADDR_W-1:0] addr);
      pool_reply_type r;
      logic [63:0] cnt, span, off, n, sum;
      bit          found;
      cnt           = 64'(slot_limit());
      found         = 1'b0;
      r.status      = STATUS_STRAY;
      r.slot        = SLOT_NONE;
      r.object_addr = '0;
      if (op == OP_ALLOC) begin
         r.status = STATUS_FULL;
         // Lowest free slot wins; bits at or above the slot count are not looked at.
         for (int i = 0; i < cnt && !found; i++) begin
            if (!used_map[i]) begin
               found         = 1'b1;
               used_map[i]   = 1'b1;
               sum           = 64'(cfg_base) + 64'(cfg_size) * 64'(i);
               r.status      = STATUS_OK;
               r.slot        = i[SLOT_ID_W-1:0];
               r.object_addr = sum[ADDR_W-1:0];  // the address wraps at 48 bits
            end
         end
      end else begin
         // The range check uses the unwrapped offset from the base. A zero
         // object size covers no addresses at all, so every free is stray.
         span = 64'(cfg_size) * cnt;
         if (addr >= cfg_base && cfg_size != 0) begin
            off = 64'(addr) - 64'(cfg_base);
            if (off < span && off % cfg_size == 0) begin
               n = off / cfg_size;
               if (n < cnt) begin
                  // Clearing a bit that is already clear is a harmless double free.
                  used_map[n[5:0]] = 1'b0;
                  r.status         = STATUS_OK;
                  r.slot           = n[SLOT_ID_W-1:0];
               end
            end
         end
      end
      return r;
   endfunction

   // Request driver. The prediction is made at the edge where the word is
   // accepted; a new word is offered only once the bus is free, and a word
   // once offered stays on the bus until it is taken.
   always @(posedge clock) begin : drive_requests
      pool_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            reply_q.push_back(pool_outcome(req_tuser, req_tdata));
         if (!req_tvalid || req_tready) begin
            if (request_q.size() > 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
               nxt = request_q.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= nxt.op;
               req_tdata  <= nxt.addr;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor. It compares each accepted word with the oldest owed
   // response and decides the ready level for the next cycle, including the
   // long hold-off that lets the block fill up and stall its request side.
   always @(posedge clock) begin : check_responses
      pool_reply_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (reply_q.size() == 0) begin
               $error("response word arrived with no request outstanding");
               error_count++;
            end else begin
               want = reply_q.pop_front();
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tuser);
                  error_count++;
               end
               if (rsp_tdata[6:0] !== want.slot) begin
                  $error("slot_id: expected %0d, got %0d",
                         $signed(want.slot), $signed(rsp_tdata[6:0]));
                  error_count++;
               end
               if (rsp_tdata[54:7] !== want.object_addr) begin
                  $error("object_addr: expected 0x%h, got 0x%h",
                         want.object_addr, rsp_tdata[54:7]);
                  error_count++;
               end
            end
         end
         if (hold_left == 0 && hold_seen != hold_asks) begin
            hold_seen++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= no_gaps || $urandom_range(99) >= IDLE_PCT;
         end
      end
   end

   function automatic logic [ADDR_W-1:0] random_addr();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[ADDR_W-1:0];
   endfunction

   // Mostly addresses of real slots, which may or may not be in use, plus random
   // addresses and some near misses: off a slot boundary, one past the pool, one below it.
   function automatic logic [ADDR_W-1:0] free_address();
      int          cnt;
      logic [63:0] span, idx;
      cnt  = slot_limit();
      span = 64'(cfg_size) * 64'(cnt);
      idx  = 64'($urandom_range(cnt > 0 ? cnt - 1 : 0));
      case ($urandom_range(19))
         0:       return random_addr();
         1:       return ADDR_W'(64'(cfg_base) + 64'(cfg_size) * idx + 64'd1);
         2:       return ADDR_W'(64'(cfg_base) + span);
         3:       return cfg_base - 48'd1;
         default: return ADDR_W'(64'(cfg_base) + 64'(cfg_size) * idx);
      endcase
   endfunction

   task automatic add_request(logic op, logic [ADDR_W-1:0] addr);
      request_q.push_back('{op, addr});
   endtask

   // Bursts that lean toward allocating alternate with bursts that lean
   // toward freeing, so the pool keeps running full and draining again.
   task automatic queue_traffic(int n);
      int left, burst, fill_pct;
      bit filling;
      left    = n;
      filling = 1'b1;
      while (left > 0) begin
         burst    = $urandom_range(4, 2 * slot_limit() + 6);
         fill_pct = filling ? 80 : 25;
         for (int k = 0; k < burst && left > 0; k++) begin
            if ($urandom_range(99) < fill_pct)
               add_request(OP_ALLOC, random_addr());
            else
               add_request(OP_FREE, free_address());
            left--;
         end
         filling = !filling;
      end
   endtask

   // Returns once every word has been taken and every response has arrived.
   task automatic wait_idle();
      while (request_q.size() != 0 || req_tvalid || reply_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_AW-1:0] idx, logic [ADDR_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_POOL_BASE:    cfg_base  = value;
         CSR_OBJECT_SIZE:  cfg_size  = value[SIZE_W-1:0];
         CSR_SLOTS_IN_USE: cfg_slots = value[CNT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(logic [ADDR_W-1:0] base, logic [SIZE_W-1:0] size,
                            logic [CNT_W-1:0] slots);
      csr_write(CSR_POOL_BASE, base);
      csr_write(CSR_OBJECT_SIZE, 48'(size));
      csr_write(CSR_SLOTS_IN_USE, 48'(slots));
   endtask

   initial begin : run_test
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset configuration: base 0, 64-byte objects, 64 slots. Covers a
      // double free, a misaligned free, the first byte past the pool and the
      // top of the address space.
      add_request(OP_ALLOC, ADDR_TOP);
      add_request(OP_ALLOC, '0);
      add_request(OP_FREE, 48'd64);
      add_request(OP_FREE, 48'd64);
      add_request(OP_FREE, 48'd32);
      add_request(OP_FREE, 48'd4096);
      add_request(OP_FREE, ADDR_TOP);
      add_request(OP_FREE, 48'd0);
      add_request(OP_ALLOC, '0);
      wait_idle();

      // Slot count above capacity, and a pool that sits at the top of the
      // address space: the second slot's address wraps to zero, and freeing
      // that wrapped address falls below the base.
      configure(48'hFFFF_FFFF_FFF0, 16'd16, 7'd127);
      add_request(OP_ALLOC, '0);
      add_request(OP_FREE, 48'hFFFF_FFFF_FFF0);
      add_request(OP_FREE, 48'd0);
      add_request(OP_FREE, 48'hFFFF_FFFF_FFF8);
      add_request(OP_ALLOC, '0);
      wait_idle();

      // Empty pool: everything is full or stray.
      csr_write(CSR_SLOTS_IN_USE, 48'd0);
      add_request(OP_ALLOC, '0);
      add_request(OP_FREE, 48'hFFFF_FFFF_FFF0);
      wait_idle();

      // Zero object size: every claimed slot reports the base address.
      configure(48'd100, 16'd0, 7'd4);
      add_request(OP_ALLOC, '0);
      add_request(OP_ALLOC, '0);
      add_request(OP_ALLOC, '0);
      add_request(OP_FREE, 48'd100);
      wait_idle();

      // Shrunk pool: slots beyond the new count keep their bits.
      configure(48'd0, 16'd64, 7'd2);
      add_request(OP_ALLOC, '0);
      add_request(OP_FREE, 48'd128);
      add_request(OP_FREE, 48'd64);
      add_request(OP_ALLOC, '0);
      wait_idle();

      // Random traffic over a range of settings. The first phase also has the
      // receiver hold off long enough for the request side to back up.
      configure(48'd0, 16'd64, 7'd64);
      queue_traffic(150);
      hold_asks <= hold_asks + 1;
      wait_idle();

      configure(random_addr(), 16'($urandom_range(1, 65535)), 7'd8);
      queue_traffic(130);
      wait_idle();

      configure(ADDR_TOP - 48'd200, 16'hFFFF, 7'd64);
      queue_traffic(100);
      wait_idle();

      configure(48'd0, 16'd1, 7'd1);
      queue_traffic(80);
      wait_idle();

      // A stretch with no gaps on either side, again with one long hold-off.
      no_gaps <= 1'b1;
      configure(random_addr(), 16'd3, 7'd13);
      queue_traffic(150);
      hold_asks <= hold_asks + 1;
      wait_idle();
      no_gaps <= 1'b0;

      configure(random_addr(), 16'd24, 7'd100);
      queue_traffic(90);
      wait_idle();

      csr_write(CSR_SLOTS_IN_USE, 48'd0);
      queue_traffic(40);
      wait_idle();

      configure(random_addr(), 16'd0, 7'd5);
      queue_traffic(40);
      wait_idle();

      for (int p = 0; p < 3; p++) begin
         configure(random_addr(), 16'($urandom_range(1, 65535)),
                   7'($urandom_range(1, POOL_CAP)));
         queue_traffic(40);
         wait_idle();
      end

      // Any stray response word that shows up late is still caught here.
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin : watchdog
      #(4_000_000);
      $display("FAIL");
      $finish;
   end

endmodule

// ----- bitmap_object_pool_allocator.f -----
sv/bopa_pkg.sv
sv/bopa_ram.sv
sv/bopa_div.sv
sv/bitmap_object_pool_allocator.sv
tb/tb_bitmap_object_pool_allocator.sv
